// ----- rtl/moorm_pkg.sv -----
`timescale 1ns / 1ps

package moorm_pkg;

	// field widths
	localparam int SMP_W  = 12;
	localparam int CNT_W  = 5;
	localparam int MEAN_W = 20;
	localparam int FRAC_W = 8;

	// stream data widths, padded to whole bytes
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 40;

	localparam int SAMPLE_COUNT_DEF = 20;

	localparam logic [SMP_W-1:0] TOL_RESET = SMP_W'(2);

endpackage

// ----- rtl/moorm_store.sv -----
`timescale 1ns / 1ps

// Sample memory: one write port, two read ports, registered read data.
module moorm_store #(
	parameter int DEPTH = moorm_pkg::SAMPLE_COUNT_DEF,
	parameter int AW    = $clog2(moorm_pkg::SAMPLE_COUNT_DEF)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [moorm_pkg::SMP_W-1:0] wdata,
	input  logic [AW-1:0]               addr_a,
	input  logic [AW-1:0]               addr_b,
	output logic [moorm_pkg::SMP_W-1:0] rd_a,
	output logic [moorm_pkg::SMP_W-1:0] rd_b
);

	logic [moorm_pkg::SMP_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_a <= mem[addr_a];
		rd_b <= mem[addr_b];
	end

endmodule

// ----- rtl/moorm_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module moorm_div #(
	parameter int DVD_W = 26,
	parameter int DVS_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [STEP_W-1:0] step_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DVS_W'(rem_sh - {1'b0, dvs_q});
			end else begin
				rem_q <= rem_sh[DVS_W-1:0];
			end
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/median_outlier_rejecting_mean.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Handshake                Payload
// s_axis   in   s_tvalid / s_tready      s_tdata[11:0]  adc_sample
// m_axis   out  m_tvalid / m_tready      m_tdata: median_value, kept_count, filtered_mean_q8
// cfg      in   cfg_valid / cfg_ready    cfg_data[11:0] outlier_tolerance
//
// Samples are taken one per cycle while collecting; after the last one of a window
// s_tready drops. Then follow the median search (one compare per cycle), the kept
// pass, the divide (one shift per dividend bit) and the output load, which waits
// while a previous result is still held unaccepted on m_axis. Reset clears control,
// loads the tolerance with 2 and leaves the memory alone. A stalled result holds
// in the output register while the next window is collected.
module median_outlier_rejecting_mean #(
	parameter int SAMPLE_COUNT = moorm_pkg::SAMPLE_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [11:0] adc_sample
	input  logic [moorm_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [11:0] median_value, [16:12] kept_count, [36:17] filtered_mean_q8
	output logic [moorm_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [moorm_pkg::SMP_W-1:0]       cfg_data
);

	localparam int SMP_W  = moorm_pkg::SMP_W;
	localparam int IDX_W  = $clog2(SAMPLE_COUNT);
	localparam int KW     = $clog2(SAMPLE_COUNT + 1);
	localparam int SUM_W  = SMP_W + KW;
	localparam int DVD_W  = SUM_W + moorm_pkg::FRAC_W;
	localparam int PAD_W  = moorm_pkg::OUT_TDATA_W - SMP_W - moorm_pkg::CNT_W
		- moorm_pkg::MEAN_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLE_COUNT - 1);
	localparam logic [KW-1:0]    RANK     = KW'(SAMPLE_COUNT / 2);

	localparam logic [2:0] S_COLLECT = 3'd0;
	localparam logic [2:0] S_SELECT  = 3'd1;
	localparam logic [2:0] S_MEAN    = 3'd2;
	localparam logic [2:0] S_DIV     = 3'd3;
	localparam logic [2:0] S_OUT     = 3'd4;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] fill_q;
	logic [IDX_W-1:0] cand_q;
	logic [IDX_W-1:0] sweep_q;
	logic             iss_q;
	logic             vld_s1;
	logic             last_s1;
	logic [KW-1:0]    lt_q;
	logic [KW-1:0]    le_q;
	logic [KW-1:0]    kept_q;
	logic [SUM_W-1:0] sum_q;
	logic [SMP_W-1:0] tol_q;
	logic [SMP_W-1:0] med_q;
	logic             out_valid_q;
	logic [SMP_W-1:0] out_med_q;
	logic [moorm_pkg::CNT_W-1:0]  out_cnt_q;
	logic [moorm_pkg::MEAN_W-1:0] out_mean_q;

	logic [SMP_W-1:0] rd_a;
	logic [SMP_W-1:0] rd_b;
	logic             in_fire;
	logic [KW-1:0]    lt_n;
	logic [KW-1:0]    le_n;
	logic             hit;
	logic [SMP_W-1:0] delta;
	logic             keep;
	logic [KW-1:0]    kept_n;
	logic [SUM_W-1:0] sum_n;
	logic             div_start;
	logic             div_done;
	logic [DVD_W-1:0] div_quo;
	logic             out_load;

	assign s_tready  = (state_q == S_COLLECT);
	assign cfg_ready = 1'b1;
	assign in_fire   = s_tvalid && s_tready;

	moorm_store #(
		.DEPTH (SAMPLE_COUNT),
		.AW    (IDX_W)
	) u_store (
		.clk    (clk),
		.we     (in_fire),
		.waddr  (fill_q),
		.wdata  (s_tdata[SMP_W-1:0]),
		.addr_a (cand_q),
		.addr_b (sweep_q),
		.rd_a   (rd_a),
		.rd_b   (rd_b)
	);

	// candidate rd_a has rank k when #(< it) <= k < #(<= it)
	always_comb begin
		lt_n   = lt_q + KW'(rd_b < rd_a);
		le_n   = le_q + KW'(rd_b <= rd_a);
		hit    = (state_q == S_SELECT) && vld_s1 && last_s1 && (lt_n <= RANK) &&
			(le_n > RANK);
		delta  = (rd_b >= med_q) ? (rd_b - med_q) : (med_q - rd_b);
		keep   = delta <= tol_q;
		kept_n = kept_q + KW'(keep);
		sum_n  = sum_q + (keep ? SUM_W'(rd_b) : SUM_W'(0));
	end

	assign div_start = (state_q == S_MEAN) && vld_s1 && last_s1;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || m_tready);

	moorm_div #(
		.DVD_W (DVD_W),
		.DVS_W (KW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_n, moorm_pkg::FRAC_W'(0)}),
		.divisor  (kept_n),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_COLLECT;
			fill_q      <= '0;
			cand_q      <= '0;
			sweep_q     <= '0;
			iss_q       <= 1'b0;
			vld_s1      <= 1'b0;
			last_s1     <= 1'b0;
			lt_q        <= '0;
			le_q        <= '0;
			kept_q      <= '0;
			tol_q       <= moorm_pkg::TOL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			// read issue for the search and the mean pass
			vld_s1 <= 1'b0;
			if (iss_q && (state_q == S_SELECT || state_q == S_MEAN)) begin
				vld_s1  <= 1'b1;
				last_s1 <= (sweep_q == LAST_IDX);
				if (sweep_q == LAST_IDX) begin
					sweep_q <= '0;
					if (state_q == S_SELECT) begin
						cand_q <= (cand_q == LAST_IDX) ? '0 : cand_q + IDX_W'(1);
					end else begin
						iss_q <= 1'b0;
					end
				end else begin
					sweep_q <= sweep_q + IDX_W'(1);
				end
			end

			unique case (state_q)
				S_COLLECT: begin
					if (in_fire) begin
						if (fill_q == LAST_IDX) begin
							fill_q  <= '0;
							state_q <= S_SELECT;
							cand_q  <= '0;
							sweep_q <= '0;
							iss_q   <= 1'b1;
							lt_q    <= '0;
							le_q    <= '0;
						end else begin
							fill_q <= fill_q + IDX_W'(1);
						end
					end
				end
				S_SELECT: begin
					if (vld_s1) begin
						if (last_s1) begin
							lt_q <= '0;
							le_q <= '0;
						end else begin
							lt_q <= lt_n;
							le_q <= le_n;
						end
					end
					if (hit) begin
						// drop the read still in flight and restart for the mean pass
						state_q <= S_MEAN;
						sweep_q <= '0;
						iss_q   <= 1'b1;
						vld_s1  <= 1'b0;
						kept_q  <= '0;
					end
				end
				S_MEAN: begin
					if (vld_s1) begin
						kept_q <= kept_n;
						if (last_s1) begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= S_COLLECT;
					end
				end
				default: begin
					state_q <= S_COLLECT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			med_q <= rd_a;
			sum_q <= '0;
		end else if (state_q == S_MEAN && vld_s1) begin
			sum_q <= sum_n;
		end
		if (out_load) begin
			out_med_q  <= med_q;
			out_cnt_q  <= moorm_pkg::CNT_W'(kept_q);
			out_mean_q <= moorm_pkg::MEAN_W'(div_quo);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {PAD_W'(0), out_mean_q, out_cnt_q, out_med_q};

endmodule
